@@ rtl/core/adc_average_window_alarm_core_macros.svh @@
// Assertion macros shared by the averaging alarm core.
`ifndef ADC_AVERAGE_WINDOW_ALARM_CORE_MACROS_SVH
`define ADC_AVERAGE_WINDOW_ALARM_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset
`define AAWA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked out of reset
`define AAWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define AAWA_ASSERT_NOW(label, clk, rst, ante, cons)
`define AAWA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/aawa_pkg.sv @@
// Types and constants of the averaging window alarm core.
package aawa_pkg;

  // Averaging ring geometry
  localparam int LOG2_TAPS   = 5;
  localparam int TAPS        = 1 << LOG2_TAPS;
  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = SAMPLE_BITS + LOG2_TAPS;
  localparam int COUNT_BITS  = 32;

  // Alarm hysteresis and watchdog gap
  localparam int HYSTERESIS = 50;
  localparam logic [SAMPLE_BITS-1:0] WATCH_GAP = SAMPLE_BITS'(100);

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] WATCH_HIGH_RST = SAMPLE_BITS'(2000);
  localparam logic [SAMPLE_BITS-1:0] ALARM_MAX_RST  = SAMPLE_BITS'(1489);
  localparam logic [SAMPLE_BITS-1:0] ALARM_MIN_RST  = SAMPLE_BITS'(992);

  // Register map
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WATCH_HIGH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_MAX  = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_MIN  = CFG_INDEX_BITS'(2);

  // Item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_EDGE   = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   power_pin;
  } req_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic [SAMPLE_BITS-1:0] alarm;
    logic                   lamp_on;
    logic [COUNT_BITS-1:0]  low_count;
    logic [COUNT_BITS-1:0]  high_count;
    logic                   button_state;
  } rsp_item_t;

endpackage

@@ rtl/core/adc_average_window_alarm_core.sv @@
// Moving-average window alarm with raw watchdog, pin counters and button bit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_item (command, sample, power_pin)
//   rsp      out        rsp_valid/rsp_stall   rsp_item (average ... button_state)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while the result side is not stalled; each item passes
// the ring memory read register, then the update and result register.
// Reset (rst, synchronous) clears the ring valid bits, sum, pointer and flags;
// registers return to their reset values. No clearing pass is needed.
// A stalled result holds the update stage, which then stalls the request side.
`include "adc_average_window_alarm_core_macros.svh"

module adc_average_window_alarm_core (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          req_valid,
  output logic                                          req_stall,
  input  aawa_pkg::req_item_t                           req_item,
  output logic                                          rsp_valid,
  input  logic                                          rsp_stall,
  output aawa_pkg::rsp_item_t                           rsp_item,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [aawa_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [aawa_pkg::SAMPLE_BITS-1:0]              cfg_data
);

  localparam int SB = aawa_pkg::SAMPLE_BITS;
  localparam int WB = aawa_pkg::SAMPLE_BITS + 2;
  localparam logic [WB-1:0] HYST_W = WB'(aawa_pkg::HYSTERESIS);

  // Configuration registers
  logic [SB-1:0] watch_high;
  logic [SB-1:0] alarm_max;
  logic [SB-1:0] alarm_min;

  // Ring memory and its per-entry valid bits
  logic [SB-1:0]                 ring_mem [aawa_pkg::TAPS];
  logic [SB-1:0]                 rd_data;
  logic [aawa_pkg::TAPS-1:0]     ring_valid;
  logic [aawa_pkg::LOG2_TAPS-1:0] ring_pointer;

  // Block state
  logic [aawa_pkg::SUM_BITS-1:0]   running_sum;
  logic                            alarm_flag;
  logic                            lamp_state;
  logic [aawa_pkg::COUNT_BITS-1:0] low_counter;
  logic [aawa_pkg::COUNT_BITS-1:0] high_counter;
  logic                            button_bit;

  // Read stage
  logic                           s1_valid;
  aawa_pkg::req_item_t            s1_item;
  logic [aawa_pkg::LOG2_TAPS-1:0] s1_idx;

  // Handshake and update signals
  logic                            req_accept;
  logic                            s1_adv;
  logic                            s1_sample;
  logic [SB-1:0]                   old_sample;
  logic [aawa_pkg::SUM_BITS-1:0]   sum_next;
  logic [SB-1:0]                   avg_next;
  logic [SB-1:0]                   avg_now;
  logic [WB-1:0]                   avg_w;
  logic [WB-1:0]                   max_w;
  logic [WB-1:0]                   min_w;
  logic                            alarm_next;
  logic [SB-1:0]                   low_thr;
  logic                            lamp_next;
  logic [aawa_pkg::COUNT_BITS-1:0] low_next;
  logic [aawa_pkg::COUNT_BITS-1:0] high_next;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall  = s1_valid && !s1_adv;
  assign req_accept = req_valid && !req_stall;
  assign s1_sample  = (s1_item.command == aawa_pkg::CMD_SAMPLE);

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      watch_high <= aawa_pkg::WATCH_HIGH_RST;
      alarm_max  <= aawa_pkg::ALARM_MAX_RST;
      alarm_min  <= aawa_pkg::ALARM_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        aawa_pkg::REG_WATCH_HIGH: watch_high <= cfg_data;
        aawa_pkg::REG_ALARM_MAX:  alarm_max  <= cfg_data;
        aawa_pkg::REG_ALARM_MIN:  alarm_min  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ring memory: read the entry about to be replaced, write back on update
  always_ff @(posedge clk) begin
    if (s1_adv && s1_sample) begin
      ring_mem[s1_idx] <= s1_item.sample;
    end
    if (req_accept) begin
      rd_data <= ring_mem[ring_pointer];
    end
  end

  // Load the read stage and advance the ring pointer on sample items
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      ring_pointer <= '0;
    end else begin
      if (req_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (req_accept && req_item.command == aawa_pkg::CMD_SAMPLE) begin
        ring_pointer <= ring_pointer + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_item <= req_item;
      s1_idx  <= ring_pointer;
    end
  end

  // Compute the updated sum, alarm, lamp and counters
  always_comb begin
    old_sample = ring_valid[s1_idx] ? rd_data : '0;
    sum_next   = running_sum + aawa_pkg::SUM_BITS'(s1_item.sample)
                 - aawa_pkg::SUM_BITS'(old_sample);
    avg_next   = sum_next[aawa_pkg::SUM_BITS-1 -: SB];
    avg_now    = running_sum[aawa_pkg::SUM_BITS-1 -: SB];
    avg_w      = WB'(avg_next);
    max_w      = WB'(alarm_max);
    min_w      = WB'(alarm_min);
    if (alarm_flag) begin
      alarm_next = (avg_w + HYST_W > max_w) || (avg_w < min_w + HYST_W);
    end else begin
      alarm_next = (avg_w > max_w) || (avg_w < min_w);
    end
    low_thr = watch_high - aawa_pkg::WATCH_GAP;
    if (s1_item.sample > watch_high) begin
      lamp_next = 1'b0;
    end else if (s1_item.sample < low_thr) begin
      lamp_next = 1'b1;
    end else begin
      lamp_next = lamp_state;
    end
    low_next  = low_counter + (s1_item.power_pin ? 32'd0 : 32'd1);
    high_next = high_counter + (s1_item.power_pin ? 32'd1 : 32'd0);
  end

  // Commit the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid   <= '0;
      running_sum  <= '0;
      alarm_flag   <= 1'b0;
      lamp_state   <= 1'b0;
      low_counter  <= '0;
      high_counter <= '0;
      button_bit   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_sample) begin
        ring_valid[s1_idx] <= 1'b1;
        running_sum        <= sum_next;
        alarm_flag         <= alarm_next;
        lamp_state         <= lamp_next;
        low_counter        <= low_next;
        high_counter       <= high_next;
      end else begin
        button_bit   <= ~button_bit;
        low_counter  <= '0;
        high_counter <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_sample) begin
        rsp_item.average      <= avg_next;
        rsp_item.alarm        <= SB'(alarm_next);
        rsp_item.lamp_on      <= lamp_next;
        rsp_item.low_count    <= low_next;
        rsp_item.high_count   <= high_next;
        rsp_item.button_state <= button_bit;
      end else begin
        rsp_item.average      <= avg_now;
        rsp_item.alarm        <= SB'(alarm_flag);
        rsp_item.lamp_on      <= lamp_state;
        rsp_item.low_count    <= '0;
        rsp_item.high_count   <= '0;
        rsp_item.button_state <= ~button_bit;
      end
    end
  end

  `AAWA_ASSERT_NOW(a_alarm_is_bit, clk, rst, rsp_valid, rsp_item.alarm[SB-1:1] == '0)
  `AAWA_ASSERT_NEXT(a_edge_clears_counts, clk, rst, s1_adv && !s1_sample, rsp_item.low_count == '0 && rsp_item.high_count == '0)
  `AAWA_ASSERT_NEXT(a_pointer_step, clk, rst, req_accept && req_item.command == aawa_pkg::CMD_SAMPLE, ring_pointer == $past(ring_pointer) + 1'b1)
  `AAWA_ASSERT_NEXT(a_read_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(rd_data) && $stable(s1_idx))

endmodule
